[design/ibr_pkg.sv]
// ----------------------------------------------------------------------------
// ibr_pkg
// Shared types and constants of the IR blob report decoder.
// ----------------------------------------------------------------------------
package ibr_pkg;

  localparam int unsigned NUM_BLOBS = 4;
  localparam int unsigned SLOT_W    = (NUM_BLOBS > 1) ? $clog2(NUM_BLOBS) : 1;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DELTA_W = 11;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX          = 3'd7;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = 4'd15;

  // status byte layout
  localparam logic [BYTE_W-1:0] SIZE_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] XHI_MASK  = 8'h30;
  localparam logic [BYTE_W-1:0] YHI_MASK  = 8'hC0;

  // register map
  localparam int unsigned      APB_ADDR_W         = 2;
  localparam int unsigned      APB_DATA_W         = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_SIZE_LIMIT = 2'd0;

  // one complete blob group, handed from front to back
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              new_report;
    logic [BYTE_W-1:0] low_x;
    logic [BYTE_W-1:0] low_y;
    logic [BYTE_W-1:0] status;
  } blob_op_t;

  // phase within a blob group
  typedef enum logic [1:0] {
    PH_XLO    = 2'd0,
    PH_YLO    = 2'd1,
    PH_STATUS = 2'd2
  } phase_t;

endpackage

[design/ibr_front.sv]
// ----------------------------------------------------------------------------
// ibr_front
// Byte framing: skips the header, latches the low bytes and issues one blob
// request per completed three-byte group.
// ----------------------------------------------------------------------------
module ibr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_take,
  input  logic [ibr_pkg::BYTE_W-1:0]    report_byte,
  input  logic                          report_start,
  output logic                          op_push,
  output ibr_pkg::blob_op_t             op_data
);

  logic                        open_r, open_nxt;
  ibr_pkg::phase_t             phase_r, phase_nxt;
  logic [ibr_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic                        new_rep_r, new_rep_nxt;
  logic [ibr_pkg::BYTE_W-1:0]  low_x_r, low_x_nxt;
  logic [ibr_pkg::BYTE_W-1:0]  low_y_r, low_y_nxt;

  always_comb begin
    open_nxt    = open_r;
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    new_rep_nxt = new_rep_r;
    low_x_nxt   = low_x_r;
    low_y_nxt   = low_y_r;
    op_push     = 1'b0;
    if (byte_take) begin
      if (report_start) begin
        open_nxt    = 1'b1;
        phase_nxt   = ibr_pkg::PH_XLO;
        slot_nxt    = '0;
        new_rep_nxt = 1'b1;
      end else if (open_r) begin
        unique case (phase_r)
          ibr_pkg::PH_XLO: begin
            low_x_nxt = report_byte;
            phase_nxt = ibr_pkg::PH_YLO;
          end
          ibr_pkg::PH_YLO: begin
            low_y_nxt = report_byte;
            phase_nxt = ibr_pkg::PH_STATUS;
          end
          ibr_pkg::PH_STATUS: begin
            op_push     = 1'b1;
            new_rep_nxt = 1'b0;
            phase_nxt   = ibr_pkg::PH_XLO;
            if (slot_r == ibr_pkg::SLOT_W'(ibr_pkg::NUM_BLOBS - 1)) begin
              open_nxt = 1'b0;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end
          default: begin
            phase_nxt = ibr_pkg::PH_XLO;
          end
        endcase
      end
    end
  end

  assign op_data.slot       = slot_r;
  assign op_data.new_report = new_rep_r;
  assign op_data.low_x      = low_x_r;
  assign op_data.low_y      = low_y_r;
  assign op_data.status     = report_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      phase_r   <= ibr_pkg::PH_XLO;
      slot_r    <= '0;
      new_rep_r <= 1'b0;
      low_x_r   <= '0;
      low_y_r   <= '0;
    end else begin
      open_r    <= open_nxt;
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      new_rep_r <= new_rep_nxt;
      low_x_r   <= low_x_nxt;
      low_y_r   <= low_y_nxt;
    end
  end

endmodule

[design/ibr_queue.sv]
// ----------------------------------------------------------------------------
// ibr_queue
// Two-entry queue of blob requests between front and back.
// ----------------------------------------------------------------------------
module ibr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ibr_pkg::blob_op_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ibr_pkg::blob_op_t pop_data
);

  ibr_pkg::blob_op_t entry_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[design/ibr_back.sv]
// ----------------------------------------------------------------------------
// ibr_back
// Blob evaluation: visibility test, per-slot position and motion store,
// visible count and the registered result stage.
// ----------------------------------------------------------------------------
module ibr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ibr_pkg::SIZE_W-1:0]    size_limit,
  input  logic                          op_valid,
  input  ibr_pkg::blob_op_t             op_data,
  output logic                          op_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ibr_pkg::IDX_W-1:0]     out_blob_index,
  output logic                          out_visible,
  output logic [ibr_pkg::POS_W-1:0]     out_pos_x,
  output logic [ibr_pkg::POS_W-1:0]     out_pos_y,
  output logic [ibr_pkg::SIZE_W-1:0]    out_blob_size,
  output logic signed [ibr_pkg::DELTA_W-1:0] out_delta_x,
  output logic signed [ibr_pkg::DELTA_W-1:0] out_delta_y,
  output logic [ibr_pkg::CNT_W-1:0]     out_visible_count,
  output logic                          out_last_blob
);

  logic [ibr_pkg::POS_W-1:0]   sx_r  [ibr_pkg::NUM_BLOBS];
  logic [ibr_pkg::POS_W-1:0]   sy_r  [ibr_pkg::NUM_BLOBS];
  logic [ibr_pkg::DELTA_W-1:0] sdx_r [ibr_pkg::NUM_BLOBS];
  logic [ibr_pkg::DELTA_W-1:0] sdy_r [ibr_pkg::NUM_BLOBS];
  logic [ibr_pkg::CNT_W-1:0]   count_r, count_nxt, count_base;

  logic                        valid_r;
  logic [ibr_pkg::IDX_W-1:0]   idx_r;
  logic                        vis_r;
  logic [ibr_pkg::POS_W-1:0]   px_r, py_r;
  logic [ibr_pkg::SIZE_W-1:0]  size_r;
  logic [ibr_pkg::DELTA_W-1:0] dx_r, dy_r;
  logic [ibr_pkg::CNT_W-1:0]   cnt_out_r;
  logic                        last_r;

  logic [ibr_pkg::SIZE_W-1:0]  size;
  logic                        vis;
  logic [ibr_pkg::POS_W-1:0]   nx, ny;
  logic [ibr_pkg::DELTA_W-1:0] dx, dy;
  logic [ibr_pkg::SLOT_W+1:0]  slot_ext;
  logic [ibr_pkg::BYTE_W-1:0]  xhi, yhi;

  assign op_pop = op_valid && (!valid_r || !out_stall);

  always_comb begin
    size = ibr_pkg::SIZE_W'(op_data.status & ibr_pkg::SIZE_MASK);
    vis  = size < size_limit;
    xhi  = (op_data.status & ibr_pkg::XHI_MASK) >> 4;
    yhi  = (op_data.status & ibr_pkg::YHI_MASK) >> 6;
    nx   = {xhi[1:0], op_data.low_x};
    ny   = {yhi[1:0], op_data.low_y};
    dx   = {1'b0, nx} - {1'b0, sx_r[op_data.slot]};
    dy   = {1'b0, ny} - {1'b0, sy_r[op_data.slot]};
    // a header resets the count; the flag rides on the first blob after it
    count_base = op_data.new_report ? '0 : count_r;
    count_nxt  = (vis && count_base != ibr_pkg::CNT_MAX) ? count_base + 1'b1 : count_base;
    slot_ext   = {2'b00, op_data.slot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ibr_pkg::NUM_BLOBS; i++) begin
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        sdx_r[i] <= '0;
        sdy_r[i] <= '0;
      end
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (op_pop) begin
        count_r <= count_nxt;
        if (vis) begin
          sx_r[op_data.slot]  <= nx;
          sy_r[op_data.slot]  <= ny;
          sdx_r[op_data.slot] <= dx;
          sdy_r[op_data.slot] <= dy;
        end
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      idx_r     <= slot_ext[ibr_pkg::IDX_W-1:0];
      vis_r     <= vis;
      px_r      <= vis ? nx : sx_r[op_data.slot];
      py_r      <= vis ? ny : sy_r[op_data.slot];
      size_r    <= size;
      dx_r      <= vis ? dx : sdx_r[op_data.slot];
      dy_r      <= vis ? dy : sdy_r[op_data.slot];
      cnt_out_r <= count_nxt;
      last_r    <= (op_data.slot == ibr_pkg::SLOT_W'(ibr_pkg::NUM_BLOBS - 1));
    end
  end

  assign out_valid         = valid_r;
  assign out_blob_index    = idx_r;
  assign out_visible       = vis_r;
  assign out_pos_x         = px_r;
  assign out_pos_y         = py_r;
  assign out_blob_size     = size_r;
  assign out_delta_x       = $signed(dx_r);
  assign out_delta_y       = $signed(dy_r);
  assign out_visible_count = cnt_out_r;
  assign out_last_blob     = last_r;

endmodule

[design/ir_blob_report_decoder.sv]
// Each accepted status byte goes through the request queue, then the result register.
// Throughput: one report byte per cycle while in_stall is low; the back end retires
// one blob request per cycle while out_stall does not hold its result register, so
// the two-entry queue only fills under output stall.
// Reset: synchronous, active low; clears framing, slot store, count and
// sets size_limit to 15.
// ----------------------------------------------------------------------------
// ir_blob_report_decoder
// Decodes extended-mode IR camera blob reports into per-blob results.
// ----------------------------------------------------------------------------
module ir_blob_report_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // report bytes
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ibr_pkg::BYTE_W-1:0]        in_report_byte,
  input  logic                              in_report_start,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ibr_pkg::IDX_W-1:0]         out_blob_index,
  output logic                              out_visible,
  output logic [ibr_pkg::POS_W-1:0]         out_pos_x,
  output logic [ibr_pkg::POS_W-1:0]         out_pos_y,
  output logic [ibr_pkg::SIZE_W-1:0]        out_blob_size,
  output logic signed [ibr_pkg::DELTA_W-1:0] out_delta_x,
  output logic signed [ibr_pkg::DELTA_W-1:0] out_delta_y,
  output logic [ibr_pkg::CNT_W-1:0]         out_visible_count,
  output logic                              out_last_blob,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ibr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ibr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ibr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [ibr_pkg::SIZE_W-1:0] size_limit_r;
  logic                       q_full, q_not_empty, q_pop, op_push, byte_take;
  ibr_pkg::blob_op_t          push_op, pop_op;

  // register file
  assign pready = 1'b1;
  assign prdata = (paddr == ibr_pkg::ADDR_SIZE_LIMIT)
                ? ibr_pkg::APB_DATA_W'(size_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r <= ibr_pkg::SIZE_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ibr_pkg::ADDR_SIZE_LIMIT) begin
      size_limit_r <= pwdata[ibr_pkg::SIZE_W-1:0];
    end
  end

  assign in_stall  = q_full;
  assign byte_take = in_valid && !q_full;

  ibr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_take    (byte_take),
    .report_byte  (in_report_byte),
    .report_start (in_report_start),
    .op_push      (op_push),
    .op_data      (push_op)
  );

  ibr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_op)
  );

  ibr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .size_limit        (size_limit_r),
    .op_valid          (q_not_empty),
    .op_data           (pop_op),
    .op_pop            (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_blob_index    (out_blob_index),
    .out_visible       (out_visible),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_blob_size     (out_blob_size),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_visible_count (out_visible_count),
    .out_last_blob     (out_last_blob)
  );

endmodule
